// ===== sv/coap_option_integer_extract_assert.svh =====
// Assertion macros for the CoAP option integer extractor.
// Used by coap_option_integer_extract.sv; expects clk and rst_n in scope.
`ifndef COAP_OPTION_INTEGER_EXTRACT_ASSERT_SVH
`define COAP_OPTION_INTEGER_EXTRACT_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define COIE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define COIE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/coapie_pkg.sv =====
// Package for the CoAP option integer extractor: parse phases and header constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package coapie_pkg;

  // Parser phase within the option list
  typedef enum logic [2:0] {
    PH_HDR    = 3'd0,
    PH_DEXT_A = 3'd1,
    PH_DEXT_B = 3'd2,
    PH_LEXT_A = 3'd3,
    PH_LEXT_B = 3'd4,
    PH_VALUE  = 3'd5,
    PH_SKIP   = 3'd6
  } phase_t;

  // Nibble codes and extension offsets
  localparam logic [3:0]  EXT_ONE    = 4'd13;
  localparam logic [3:0]  EXT_TWO    = 4'd14;
  localparam logic [3:0]  EXT_END    = 4'd15;
  localparam logic [15:0] OFFSET_ONE = 16'd13;
  localparam logic [15:0] OFFSET_TWO = 16'd269;
  localparam logic [15:0] SHORT_MAX  = 16'd4;

endpackage

`default_nettype wire

// ===== sv/coap_option_integer_extract.sv =====
// CoAP option integer extractor: byte-stream option walker with registered result.
// Depends on coapie_pkg and coap_option_integer_extract_assert.svh.
//
// Usage:
//   in_*  : one packet byte per transaction. in_tuser flags fixed header and
//           token bytes, which the parser skips. in_tlast marks the final byte.
//   out_* : exactly one transaction per packet, issued after its last byte:
//           out_tuser = found, out_tdata = option value (0 when not found or
//           when the option length is not 1 to 4 bytes).
//   cfg_* : cfg_we writes cfg_wdata into the target option number; write it
//           only while no packet is in flight.
// Result: out_* is registered and shows the result in the cycle after the last byte is taken.
// Throughput: one byte per cycle while in_tready is high; each byte passes through a single
// phase update (one extension add and one option number add/compare).
// Stall: while a result waits and out_tready is low, in_tready is low, so
// the input holds until the pending result is taken; with out_tready high
// a byte can be taken in every cycle.
// Reset: parser returns to expecting an option header, option number zero,
// no result pending, target option zero. Parser state also clears after
// every packet; the target option keeps its value.
`timescale 1ns / 1ps
`default_nettype none

`include "coap_option_integer_extract_assert.svh"

module coap_option_integer_extract (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,   // target_option
  // packet byte stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] packet_byte
  input  wire logic        in_tuser,    // [0] skip_byte
  input  wire logic        in_tlast,    // last_byte
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,   // [31:0] option_value
  output logic             out_tuser    // [0] found
);

  // Parser state
  coapie_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] target_r;
  logic [15:0] option_number_r, option_number_nxt;
  logic [7:0]  nibbles_r, nibbles_nxt;
  logic [15:0] pending_delta_r, pending_delta_nxt;
  logic [7:0]  ext_high_r, ext_high_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic        value_short_r, value_short_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        stopped_r, stopped_nxt;
  logic        hit_r, hit_nxt;

  // Result register
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_value_r, out_value_nxt;
  logic        out_found_r, out_found_nxt;

  logic in_accept;
  logic parse_en;
  logic        pkt_hit;
  logic [31:0] pkt_value;

  assign in_accept = in_tvalid && in_tready;
  assign parse_en  = in_accept && !in_tuser && !stopped_r;

  // Next-state logic of the option parser
  always_comb begin
    logic [3:0]  dn;
    logic [3:0]  ln;
    logic [15:0] delta_val;
    logic [15:0] len_val;
    logic [15:0] bl_dec;
    logic [16:0] sum;
    logic        delta_fin;
    logic        hdr_fin;

    phase_nxt         = phase_r;
    option_number_nxt = option_number_r;
    nibbles_nxt       = nibbles_r;
    pending_delta_nxt = pending_delta_r;
    ext_high_nxt      = ext_high_r;
    bytes_left_nxt    = bytes_left_r;
    value_short_nxt   = value_short_r;
    acc_nxt           = acc_r;
    stopped_nxt       = stopped_r;
    hit_nxt           = hit_r;

    dn        = nibbles_r[7:4];
    delta_val = pending_delta_r;
    len_val   = 16'd0;
    bl_dec    = bytes_left_r - 16'd1;
    delta_fin = 1'b0;
    hdr_fin   = 1'b0;

    if (parse_en) begin
      case (phase_r)
        coapie_pkg::PH_HDR: begin
          nibbles_nxt = in_tdata;
          if (in_tdata[7:4] == coapie_pkg::EXT_END) begin
            stopped_nxt = 1'b1;
          end else if (in_tdata[7:4] == coapie_pkg::EXT_ONE ||
                       in_tdata[7:4] == coapie_pkg::EXT_TWO) begin
            phase_nxt = coapie_pkg::PH_DEXT_A;
          end else begin
            delta_val = {12'd0, in_tdata[7:4]};
            delta_fin = 1'b1;
          end
        end
        coapie_pkg::PH_DEXT_A: begin
          if (dn == coapie_pkg::EXT_ONE) begin
            delta_val = {8'd0, in_tdata} + coapie_pkg::OFFSET_ONE;
            delta_fin = 1'b1;
          end else begin
            ext_high_nxt = in_tdata;
            phase_nxt    = coapie_pkg::PH_DEXT_B;
          end
        end
        coapie_pkg::PH_DEXT_B: begin
          delta_val = {ext_high_r, in_tdata} + coapie_pkg::OFFSET_TWO;
          delta_fin = 1'b1;
        end
        coapie_pkg::PH_LEXT_A: begin
          if (nibbles_r[3:0] == coapie_pkg::EXT_ONE) begin
            len_val = {8'd0, in_tdata} + coapie_pkg::OFFSET_ONE;
            hdr_fin = 1'b1;
          end else begin
            ext_high_nxt = in_tdata;
            phase_nxt    = coapie_pkg::PH_LEXT_B;
          end
        end
        coapie_pkg::PH_LEXT_B: begin
          len_val = {ext_high_r, in_tdata} + coapie_pkg::OFFSET_TWO;
          hdr_fin = 1'b1;
        end
        coapie_pkg::PH_VALUE: begin
          // shift in value bytes big-endian; long values read as zero
          if (value_short_r) begin
            acc_nxt = {acc_r[23:0], in_tdata};
          end
          bytes_left_nxt = bl_dec;
          if (bl_dec == 16'd0) begin
            hit_nxt     = 1'b1;
            stopped_nxt = 1'b1;
            if (!value_short_r) begin
              acc_nxt = 32'd0;
            end
          end
        end
        coapie_pkg::PH_SKIP: begin
          bytes_left_nxt = bl_dec;
          if (bl_dec == 16'd0) begin
            phase_nxt = coapie_pkg::PH_HDR;
          end
        end
        default: begin
          phase_nxt = coapie_pkg::PH_HDR;
        end
      endcase
    end

    // Delta complete: inspect the length nibble
    ln = nibbles_nxt[3:0];
    if (delta_fin) begin
      pending_delta_nxt = delta_val;
      if (ln == coapie_pkg::EXT_END) begin
        stopped_nxt = 1'b1;
      end else if (ln == coapie_pkg::EXT_ONE || ln == coapie_pkg::EXT_TWO) begin
        phase_nxt = coapie_pkg::PH_LEXT_A;
      end else begin
        len_val = {12'd0, ln};
        hdr_fin = 1'b1;
      end
    end

    // Header complete: compare unwrapped option number with the target
    sum = {1'b0, option_number_r} + {1'b0, delta_val};
    if (hdr_fin) begin
      if (sum == {1'b0, target_r}) begin
        acc_nxt = 32'd0;
        if (len_val == 16'd0) begin
          hit_nxt     = 1'b1;
          stopped_nxt = 1'b1;
        end else begin
          phase_nxt       = coapie_pkg::PH_VALUE;
          bytes_left_nxt  = len_val;
          value_short_nxt = (len_val <= coapie_pkg::SHORT_MAX);
        end
      end else begin
        option_number_nxt = sum[15:0];
        bytes_left_nxt    = len_val;
        phase_nxt = (len_val == 16'd0) ? coapie_pkg::PH_HDR : coapie_pkg::PH_SKIP;
      end
    end

    // Hold the packet outcome ahead of the end-of-packet clear
    pkt_hit   = hit_nxt;
    pkt_value = acc_nxt;

    // End of packet: return to the reset state
    if (in_accept && in_tlast) begin
      phase_nxt         = coapie_pkg::PH_HDR;
      option_number_nxt = 16'd0;
      nibbles_nxt       = 8'd0;
      pending_delta_nxt = 16'd0;
      ext_high_nxt      = 8'd0;
      bytes_left_nxt    = 16'd0;
      value_short_nxt   = 1'b0;
      acc_nxt           = 32'd0;
      stopped_nxt       = 1'b0;
      hit_nxt           = 1'b0;
    end
  end

  // Handshake and result register next values
  always_comb begin
    in_tready     = !out_valid_r || out_tready;
    out_valid_nxt = out_valid_r && !out_tready;
    out_found_nxt = out_found_r;
    out_value_nxt = out_value_r;
    if (in_accept && in_tlast) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = pkt_hit;
      out_value_nxt = pkt_hit ? pkt_value : 32'd0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_found_r;

  // Hold target option; write on cfg_we
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= 16'd0;
    end else if (cfg_we) begin
      target_r <= cfg_wdata;
    end
  end

  // Advance parser and result control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= coapie_pkg::PH_HDR;
      option_number_r <= 16'd0;
      nibbles_r       <= 8'd0;
      pending_delta_r <= 16'd0;
      ext_high_r      <= 8'd0;
      bytes_left_r    <= 16'd0;
      value_short_r   <= 1'b0;
      acc_r           <= 32'd0;
      stopped_r       <= 1'b0;
      hit_r           <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      phase_r         <= phase_nxt;
      option_number_r <= option_number_nxt;
      nibbles_r       <= nibbles_nxt;
      pending_delta_r <= pending_delta_nxt;
      ext_high_r      <= ext_high_nxt;
      bytes_left_r    <= bytes_left_nxt;
      value_short_r   <= value_short_nxt;
      acc_r           <= acc_nxt;
      stopped_r       <= stopped_nxt;
      hit_r           <= hit_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_found_r <= out_found_nxt;
    out_value_r <= out_value_nxt;
  end

  // Checks on parser and result behavior
  `COIE_ASSERT_NOW(a_miss_zero, out_tvalid && !out_tuser, out_tdata == 32'd0, "miss with nonzero value")
  `COIE_ASSERT_NEXT(a_last_gives_result, in_tvalid && in_tready && in_tlast, out_tvalid, "no result after last byte")
  `COIE_ASSERT_NEXT(a_last_clears, in_tvalid && in_tready && in_tlast, phase_r == coapie_pkg::PH_HDR && !stopped_r && !hit_r && option_number_r == 16'd0, "parser not cleared after packet")
  `COIE_ASSERT_NOW(a_hit_stops, hit_r, stopped_r, "hit without stop")
  `COIE_ASSERT_NOW(a_value_count, !stopped_r && (phase_r == coapie_pkg::PH_VALUE || phase_r == coapie_pkg::PH_SKIP), bytes_left_r != 16'd0, "value or skip phase with no bytes left")

endmodule

`default_nettype wire
